// ===== design/rfl_pkg.sv =====
// ----------------------------------------------------------------------------
// Rail fence line cipher: shared types and constants
// Control-unit states, configuration register indexes and the command
// bundle that drives the zigzag position walker.
// ----------------------------------------------------------------------------
package rfl_pkg;

   // Configuration port layout.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RAIL_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 1'b1;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] RAIL_COUNT_RESET = 5'd2;

   // Control unit: collect, permute into the result buffer, let the last
   // buffer write land, then stream the line out.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PERM   = 4'b0010,
      ST_SETTLE = 4'b0100,
      ST_DRAIN  = 4'b1000
   } state_type;

   // Commands from the control unit to the position walker.
   typedef struct packed {
      logic load;   // restart at rail 0, position 0
      logic step;   // move to the next position in rail-by-rail order
   } walk_cmd_type;

endpackage

// ===== design/rail_fence_line_cipher_core.sv =====
// ----------------------------------------------------------------------------
// Rail fence line cipher core
// Buffers one line of bytes and, on the line end, emits it permuted by the
// rail fence zigzag (encrypt) or by its inverse (decrypt).
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Beat contents
//   req      in         req_valid/req_ready  req_text_byte, req_line_end
//   rsp      out        rsp_valid/rsp_ready  rsp_out_byte, rsp_out_last,
//                                            rsp_truncated
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// Each request beat is written to the line buffer while it has room; beats past
// MAX_LINE bytes are dropped and flag the line as truncated. After the line end,
// a line of n bytes takes a start step, n permutation reads through the line
// buffer read port into the result buffer, a settle step, n reads streaming out
// of the result buffer read port and a closing step; stream-out stalls with rsp.
// Reset is synchronous and clears the control state; the buffers hold no
// reset value. Requests for the next line are taken while a line streams out,
// up to its line end. A stalled response holds in the output register.
//
module rail_fence_line_cipher_core #(
   parameter int MAX_LINE  = 64,
   parameter int MAX_RAILS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_text_byte,
   input  logic                             req_line_end,
   // Response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_out_last,
   output logic                             rsp_truncated,
   // Configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfl_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rfl_pkg::*;

   localparam int LEN_W  = $clog2(MAX_LINE + 1);
   localparam int ADDR_W = $clog2(MAX_LINE);
   localparam int RAIL_W = $clog2(MAX_RAILS + 1);
   localparam int POS_W  = $clog2(MAX_LINE + 2 * MAX_RAILS);

   // Control and configuration registers.
   state_type              state_ff, state_in;
   logic [CSR_DATA_W-1:0]  rail_cfg_ff, rail_cfg_in;
   logic                   decrypt_cfg_ff, decrypt_cfg_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic                   line_done_ff, line_done_in;
   logic [LEN_W-1:0]       n_job_ff, n_job_in;
   logic                   trunc_job_ff, trunc_job_in;
   logic                   mode_job_ff, mode_job_in;
   logic [LEN_W-1:0]       k_ff, k_in;
   logic [LEN_W-1:0]       j_ff, j_in;
   logic                   wr_valid_ff, wr_valid_in;
   logic [ADDR_W-1:0]      wr_addr_ff, wr_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_trunc_ff, rsp_trunc_in;

   // Line buffer and result buffer.
   logic [7:0]             store_mem [MAX_LINE];
   logic [7:0]             store_rd_ff;
   logic [7:0]             result_mem [MAX_LINE];
   logic [7:0]             result_rd_ff;

   logic                   req_fire;
   logic                   csr_fire;
   logic                   store_wr;
   logic                   start;
   logic                   perm_rd;
   logic                   perm_last;
   logic [ADDR_W-1:0]      store_rd_addr;
   logic                   out_free;
   logic                   drain_adv;
   logic                   drain_done;
   logic [RAIL_W-1:0]      rails_sat;
   logic [POS_W-1:0]       walk_pos;
   walk_cmd_type           walk_cmd;

   // Handshakes.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign req_ready = ~line_done_ff & (state_ff == ST_IDLE || state_ff == ST_DRAIN);
   assign req_fire  = req_valid & req_ready;
   assign store_wr  = req_fire & (len_ff < LEN_W'(MAX_LINE));

   // Phase control.
   assign start      = (state_ff == ST_IDLE) & line_done_ff;
   assign perm_rd    = (state_ff == ST_PERM);
   assign perm_last  = (k_ff == n_job_ff - LEN_W'(1));
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign drain_adv  = (state_ff == ST_DRAIN) & (j_ff != n_job_ff) & out_free;
   assign drain_done = (state_ff == ST_DRAIN) & (j_ff == n_job_ff) & out_free;

   // Rail count as used: zero acts as one rail, large values saturate.
   always_comb begin
      if (rail_cfg_ff == '0) begin
         rails_sat = RAIL_W'(1);
      end else if (32'(rail_cfg_ff) > MAX_RAILS) begin
         rails_sat = RAIL_W'(MAX_RAILS);
      end else begin
         rails_sat = RAIL_W'(rail_cfg_ff);
      end
   end

   // Zigzag position generator.
   assign walk_cmd.load = start;
   assign walk_cmd.step = perm_rd & ~perm_last;

   rfl_walker #(
      .MAX_LINE  (MAX_LINE),
      .MAX_RAILS (MAX_RAILS)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .cmd      (walk_cmd),
      .rails    (rails_sat),
      .line_len (n_job_ff),
      .pos      (walk_pos)
   );

   // Encrypt gathers from the zigzag position; decrypt scatters to it.
   assign store_rd_addr = mode_job_ff ? k_ff[ADDR_W-1:0] : walk_pos[ADDR_W-1:0];

   // Configuration registers.
   always_comb begin
      rail_cfg_in    = rail_cfg_ff;
      decrypt_cfg_in = decrypt_cfg_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_RAIL_COUNT:   rail_cfg_in    = csr_data;
            CSR_DECRYPT_MODE: decrypt_cfg_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // Line collection: fill count, overflow flag and line-complete flag.
   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      line_done_in = line_done_ff;
      if (start) begin
         len_in       = '0;
         ovf_in       = 1'b0;
         line_done_in = 1'b0;
      end else if (req_fire) begin
         if (store_wr) begin
            len_in = len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_line_end) begin
            line_done_in = 1'b1;
         end
      end
   end

   // Sequencer for the permute and stream-out phases.
   always_comb begin
      state_in     = state_ff;
      n_job_in     = n_job_ff;
      trunc_job_in = trunc_job_ff;
      mode_job_in  = mode_job_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_job_in     = len_ff;
               trunc_job_in = ovf_ff;
               mode_job_in  = decrypt_cfg_ff;
               k_in         = '0;
               state_in     = ST_PERM;
            end
         end
         ST_PERM: begin
            k_in = k_ff + LEN_W'(1);
            if (perm_last) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            j_in     = '0;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_adv) begin
               j_in = j_ff + LEN_W'(1);
            end
            if (drain_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result buffer write follows the line buffer read in the next cycle.
   assign wr_valid_in = perm_rd;
   assign wr_addr_in  = mode_job_ff ? walk_pos[ADDR_W-1:0] : k_ff[ADDR_W-1:0];

   // Output register: loaded on each stream-out read, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;
      if (drain_adv) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (j_ff == n_job_ff - LEN_W'(1));
         rsp_trunc_in = trunc_job_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rail_cfg_ff    <= RAIL_COUNT_RESET;
         decrypt_cfg_ff <= 1'b0;
         len_ff         <= '0;
         ovf_ff         <= 1'b0;
         line_done_ff   <= 1'b0;
         n_job_ff       <= '0;
         trunc_job_ff   <= 1'b0;
         mode_job_ff    <= 1'b0;
         k_ff           <= '0;
         j_ff           <= '0;
         wr_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rail_cfg_ff    <= rail_cfg_in;
         decrypt_cfg_ff <= decrypt_cfg_in;
         len_ff         <= len_in;
         ovf_ff         <= ovf_in;
         line_done_ff   <= line_done_in;
         n_job_ff       <= n_job_in;
         trunc_job_ff   <= trunc_job_in;
         mode_job_ff    <= mode_job_in;
         k_ff           <= k_in;
         j_ff           <= j_in;
         wr_valid_ff    <= wr_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wr_addr_ff   <= wr_addr_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   // Line buffer: written by request beats, read during the permute phase.
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[len_ff[ADDR_W-1:0]] <= req_text_byte;
      end
      if (perm_rd) begin
         store_rd_ff <= store_mem[store_rd_addr];
      end
   end

   // Result buffer: written in the cycle after each line buffer read,
   // read into the output register during stream-out.
   always_ff @(posedge clock) begin
      if (wr_valid_ff) begin
         result_mem[wr_addr_ff] <= store_rd_ff;
      end
      if (drain_adv) begin
         result_rd_ff <= result_mem[j_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = result_rd_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_truncated = rsp_trunc_ff;

endmodule

// ===== design/rfl_walker.sv =====
// ----------------------------------------------------------------------------
// Rail fence zigzag walker
// Produces the line positions in rail-by-rail reading order, one per step.
// On each rail the positions follow r, P-r, P+r, 2P-r, ... with period
// P = 2*(rails-1); the outer rails advance by the full period.
// ----------------------------------------------------------------------------
module rfl_walker #(
   parameter  int MAX_LINE  = 64,
   parameter  int MAX_RAILS = 16,
   localparam int LEN_W     = $clog2(MAX_LINE + 1),
   localparam int RAIL_W    = $clog2(MAX_RAILS + 1),
   localparam int POS_W     = $clog2(MAX_LINE + 2 * MAX_RAILS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rfl_pkg::walk_cmd_type cmd,
   input  logic [RAIL_W-1:0]    rails,
   input  logic [LEN_W-1:0]     line_len,
   output logic [POS_W-1:0]     pos
);
   import rfl_pkg::*;

   localparam int PER_W = $clog2(2 * MAX_RAILS);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [RAIL_W-1:0] rail_ff, rail_in;
   logic              alt_ff, alt_in;
   logic [RAIL_W-1:0] rails_ff, rails_in;

   logic [PER_W-1:0]  period;
   logic [RAIL_W:0]   rail_dbl;
   logic [PER_W-1:0]  step_size;
   logic [POS_W-1:0]  cand;
   logic [RAIL_W-1:0] rail_next;

   // Period of the zigzag; one rail walks the line straight through.
   always_comb begin
      if (rails_ff == RAIL_W'(1)) begin
         period = PER_W'(1);
      end else begin
         period = PER_W'({rails_ff - RAIL_W'(1), 1'b0});
      end
   end

   // Distance to the next position on the current rail.
   always_comb begin
      rail_dbl = {rail_ff, 1'b0};
      if (rail_ff == '0 || rail_ff == rails_ff - RAIL_W'(1)) begin
         step_size = period;
      end else if (alt_ff) begin
         step_size = PER_W'(rail_dbl);
      end else begin
         step_size = period - PER_W'(rail_dbl);
      end
      cand      = pos_ff + POS_W'(step_size);
      rail_next = rail_ff + RAIL_W'(1);
   end

   // Next walker state: stay on the rail while inside the line, else move on.
   always_comb begin
      pos_in   = pos_ff;
      rail_in  = rail_ff;
      alt_in   = alt_ff;
      rails_in = rails_ff;
      if (cmd.load) begin
         pos_in   = '0;
         rail_in  = '0;
         alt_in   = 1'b0;
         rails_in = rails;
      end else if (cmd.step) begin
         if (cand < POS_W'(line_len)) begin
            pos_in = cand;
            alt_in = ~alt_ff;
         end else begin
            rail_in = rail_next;
            pos_in  = POS_W'(rail_next);
            alt_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         rail_ff  <= '0;
         alt_ff   <= 1'b0;
         rails_ff <= RAIL_W'(1);
      end else begin
         pos_ff   <= pos_in;
         rail_ff  <= rail_in;
         alt_ff   <= alt_in;
         rails_ff <= rails_in;
      end
   end

   assign pos = pos_ff;

endmodule
